>>> rtl/hfs_pkg.sv
package hfs_pkg;

  localparam int COMP_W  = 24;
  localparam int GAIN_W  = 3;
  localparam int LEVEL_W = 16;
  localparam int COL_W   = 9;
  localparam int SAMPLE_W = 16;
  localparam int TW_W    = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd2;

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [63:0] hfs_div_cos(input int k, input logic [63:0] v);
    case (k)
      1: return v / 2;
      2: return v / 12;
      3: return v / 30;
      4: return v / 56;
      5: return v / 90;
      6: return v / 132;
      7: return v / 182;
      8: return v / 240;
      default: return v / 306;
    endcase
  endfunction

  function automatic logic [63:0] hfs_div_sin(input int k, input logic [63:0] v);
    case (k)
      1: return v / 6;
      2: return v / 20;
      3: return v / 42;
      4: return v / 72;
      5: return v / 110;
      6: return v / 156;
      7: return v / 210;
      8: return v / 272;
      default: return v / 342;
    endcase
  endfunction

  // cos or sin of a 32-bit turn fraction, Q30
  function automatic logic signed [63:0] hfs_trig(input logic [63:0] p, input logic want_sin);
    logic [63:0] r, x, x2, t;
    logic signed [63:0] cs, sn, c, s;
    logic [1:0] q;
    int k;
    q  = p[31:30];
    r  = {34'b0, p[29:0]};
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    cs = signed'(t);
    for (k = 1; k <= 9; k++) begin
      t = hfs_div_cos(k, (t * x2) >> 30);
      if (k[0]) cs = cs - signed'(t);
      else cs = cs + signed'(t);
    end
    t  = x;
    sn = signed'(t);
    for (k = 1; k <= 9; k++) begin
      t = hfs_div_sin(k, (t * x2) >> 30);
      if (k[0]) sn = sn - signed'(t);
      else sn = sn + signed'(t);
    end
    if (cs < 0) cs = 0;
    if (cs > signed'(ONE_Q30)) cs = signed'(ONE_Q30);
    if (sn < 0) sn = 0;
    if (sn > signed'(ONE_Q30)) sn = signed'(ONE_Q30);
    case (q)
      2'd0: begin c = cs;  s = sn;  end
      2'd1: begin c = -sn; s = cs;  end
      2'd2: begin c = -cs; s = -sn; end
      default: begin c = sn; s = -cs; end
    endcase
    return want_sin ? s : c;
  endfunction

  function automatic logic [SAMPLE_W-1:0] hfs_win(input logic [63:0] p);
    logic signed [63:0] v;
    v = (signed'(ONE_Q30) - hfs_trig(p, 1'b0) + 64'sd32768) >>> 16;
    if (v > 64'sd32767) v = 64'sd32767;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [TW_W-1:0] hfs_sat_q15(input logic signed [63:0] v30);
    logic signed [63:0] v;
    if (v30 < 0) v = -((-v30 + 64'sd16384) >>> 15);
    else v = (v30 + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    if (v < -64'sd32767) v = -64'sd32767;
    return v[TW_W-1:0];
  endfunction

  function automatic logic signed [TW_W-1:0] hfs_tw_re(input logic [63:0] p);
    return hfs_sat_q15(hfs_trig(p, 1'b0));
  endfunction

  function automatic logic signed [TW_W-1:0] hfs_tw_im(input logic [63:0] p);
    return hfs_sat_q15(-hfs_trig(p, 1'b1));
  endfunction

  function automatic logic signed [COMP_W-1:0] hfs_sat24(input logic signed [COMP_W+2:0] v);
    if (v > 27'sd8388607) return 24'sh7FFFFF;
    if (v < -27'sd8388608) return 24'sh800000;
    return v[COMP_W-1:0];
  endfunction

endpackage

>>> rtl/hfs_in_if.sv
interface hfs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hfs_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/hfs_out_if.sv
interface hfs_out_if;
  logic                         valid;
  logic                         ready;
  logic [hfs_pkg::COL_W-1:0]    column;
  logic [hfs_pkg::LEVEL_W-1:0]  wave_level;
  logic [hfs_pkg::LEVEL_W-1:0]  spectrum_level;
  logic                         spectrum_valid;
  logic                         frame_end;

  modport source (output valid, output column, output wave_level, output spectrum_level,
                  output spectrum_valid, output frame_end, input ready);
  modport sink (input valid, input column, input wave_level, input spectrum_level,
                input spectrum_valid, input frame_end, output ready);
endinterface

>>> rtl/hfs_sqrt_cell.sv
module hfs_sqrt_cell #(
  parameter int RW   = 52,
  parameter int TW   = 8,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [TW-1:0] in_tag,
  input  logic [RW-1:0] in_rem,
  input  logic [RW-1:0] in_root,
  output logic          out_valid,
  output logic [TW-1:0] out_tag,
  output logic [RW-1:0] out_rem,
  output logic [RW-1:0] out_root
);

  localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * STEP);

  logic [RW-1:0] trial;

  assign trial = in_root + BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_tag <= in_tag;
    if (in_rem >= trial) begin
      out_rem  <= in_rem - trial;
      out_root <= (in_root >> 1) + BIT;
    end else begin
      out_rem  <= in_rem;
      out_root <= in_root >> 1;
    end
  end

endmodule

>>> rtl/hfs_fft_engine.sv
module hfs_fft_engine #(
  parameter int FRAME_SIZE = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load_we,
  input  logic [$clog2(FRAME_SIZE)-1:0]       load_addr,
  input  logic signed [hfs_pkg::COMP_W-1:0]   load_re,
  input  logic                                start,
  input  logic [hfs_pkg::GAIN_W-1:0]          gain,
  output logic                                done,
  output logic                                spec_we,
  output logic [$clog2(FRAME_SIZE)-2:0]       spec_addr,
  output logic [hfs_pkg::LEVEL_W-1:0]         spec_level
);

  localparam int AW    = $clog2(FRAME_SIZE);
  localparam int HW    = AW - 1;
  localparam int SW    = $clog2(AW);
  localparam int CW    = hfs_pkg::COMP_W;
  localparam int DW    = 2 * CW;
  localparam int TWW   = hfs_pkg::TW_W;
  localparam int PW    = CW + TWW;
  localparam int RW    = 2 * CW + 4;
  localparam int NCELL = RW / 2;
  localparam int LW    = NCELL + 7;

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_RD    = 3'd1;
  localparam logic [2:0] E_MUL   = 3'd2;
  localparam logic [2:0] E_SUM   = 3'd3;
  localparam logic [2:0] E_WA    = 3'd4;
  localparam logic [2:0] E_WC    = 3'd5;
  localparam logic [2:0] E_MAG   = 3'd6;
  localparam logic [2:0] E_DRAIN = 3'd7;

  logic [2:0]    st;
  logic [SW-1:0] stg;
  logic [HW-1:0] n;
  logic [HW-1:0] mag_cnt;

  logic signed [TWW-1:0] tw_re_rom [FRAME_SIZE/2];
  logic signed [TWW-1:0] tw_im_rom [FRAME_SIZE/2];

  for (genvar gi = 0; gi < FRAME_SIZE / 2; gi++) begin : g_tw
    localparam logic [63:0] P = (64'(gi) << 32) / 64'(FRAME_SIZE);
    assign tw_re_rom[gi] = hfs_pkg::hfs_tw_re(P);
    assign tw_im_rom[gi] = hfs_pkg::hfs_tw_im(P);
  end

  logic [DW-1:0] mem [FRAME_SIZE];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] ra;
  logic [AW-1:0] hf;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] c_addr;
  logic [AW-1:0] k_idx;
  logic [AW-1:0] t_idx;
  logic          rd_en;
  logic [DW-1:0] rd_a;
  logic [DW-1:0] rd_c;

  logic signed [TWW-1:0] wr_q;
  logic signed [TWW-1:0] wi_q;
  logic signed [PW-1:0]  p_rr;
  logic signed [PW-1:0]  p_ii;
  logic signed [PW-1:0]  p_ri;
  logic signed [PW-1:0]  p_ir;
  logic signed [PW:0]    dr;
  logic signed [PW:0]    di;
  logic signed [PW:0]    dr_rnd;
  logic signed [PW:0]    di_rnd;
  logic signed [CW+1:0]  vr;
  logic signed [CW+1:0]  vi;
  logic signed [CW-1:0]  ar;
  logic signed [CW-1:0]  ai;
  logic signed [CW-1:0]  br;
  logic signed [CW-1:0]  bi;
  logic signed [CW+2:0]  sum_r;
  logic signed [CW+2:0]  sum_i;
  logic signed [CW+2:0]  dif_r;
  logic signed [CW+2:0]  dif_i;

  assign ar = rd_a[DW-1:CW];
  assign ai = rd_a[CW-1:0];
  assign br = rd_c[DW-1:CW];
  assign bi = rd_c[CW-1:0];

  assign hf     = AW'(1) << stg;
  assign k_idx  = AW'(n) & (hf - AW'(1));
  assign a_addr = (((AW'(n) >> stg) << stg) << 1) | k_idx;
  assign c_addr = a_addr | hf;
  assign t_idx  = k_idx << (AW - 1 - int'(stg));
  assign ra     = (st == E_IDLE || st == E_MAG) ? AW'(mag_cnt) : a_addr;
  assign rd_en  = (st == E_RD) || (st == E_MAG);

  assign sum_r = (CW+3)'(ar) + (CW+3)'(vr);
  assign sum_i = (CW+3)'(ai) + (CW+3)'(vi);
  assign dif_r = (CW+3)'(ar) - (CW+3)'(vr);
  assign dif_i = (CW+3)'(ai) - (CW+3)'(vi);

  assign dr = (PW+1)'(p_rr) - (PW+1)'(p_ii);
  assign di = (PW+1)'(p_ri) + (PW+1)'(p_ir);
  assign dr_rnd = (dr + (dr[PW] ? (PW+1)'(16383) : (PW+1)'(16384))) >>> 15;
  assign di_rnd = (di + (di[PW] ? (PW+1)'(16383) : (PW+1)'(16384))) >>> 15;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = load_addr;
    mem_wdata = {load_re, {CW{1'b0}}};
    if (load_we) begin
      mem_we = 1'b1;
    end else if (st == E_WA) begin
      mem_we    = 1'b1;
      mem_waddr = a_addr;
      mem_wdata = {hfs_pkg::hfs_sat24(sum_r), hfs_pkg::hfs_sat24(sum_i)};
    end else if (st == E_WC) begin
      mem_we    = 1'b1;
      mem_waddr = c_addr;
      mem_wdata = {hfs_pkg::hfs_sat24(dif_r), hfs_pkg::hfs_sat24(dif_i)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a <= mem[ra];
      rd_c <= mem[c_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (st == E_RD) begin
      wr_q <= tw_re_rom[t_idx[HW-1:0]];
      wi_q <= tw_im_rom[t_idx[HW-1:0]];
    end
    if (st == E_MUL) begin
      p_rr <= br * wr_q;
      p_ii <= bi * wi_q;
      p_ri <= br * wi_q;
      p_ir <= bi * wr_q;
    end
    if (st == E_SUM) begin
      vr <= dr_rnd[CW+1:0];
      vi <= di_rnd[CW+1:0];
    end
  end

  // butterfly and magnitude sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= E_IDLE;
      stg     <= '0;
      n       <= '0;
      mag_cnt <= '0;
    end else begin
      unique case (st)
        E_IDLE: begin
          if (start) begin
            stg     <= '0;
            n       <= '0;
            mag_cnt <= '0;
            st      <= E_RD;
          end
        end
        E_RD:  st <= E_MUL;
        E_MUL: st <= E_SUM;
        E_SUM: st <= E_WA;
        E_WA:  st <= E_WC;
        E_WC: begin
          n <= n + 1'b1;
          if (n == {HW{1'b1}}) begin
            stg <= stg + 1'b1;
            if (stg == SW'(AW - 1)) begin
              st <= E_MAG;
            end else begin
              st <= E_RD;
            end
          end else begin
            st <= E_RD;
          end
        end
        E_MAG: begin
          mag_cnt <= mag_cnt + 1'b1;
          if (mag_cnt == {HW{1'b1}}) begin
            st <= E_DRAIN;
          end
        end
        E_DRAIN: begin
          if (done) begin
            st <= E_IDLE;
          end
        end
        default: st <= E_IDLE;
      endcase
    end
  end

  logic                 m_v1;
  logic                 m_v2;
  logic [HW-1:0]        m_tag1;
  logic [HW-1:0]        m_tag2;
  logic [DW-1:0]        sq_re;
  logic [DW-1:0]        sq_im;
  logic [DW-1:0]        pw_sum;

  logic                 cv    [NCELL+1];
  logic [HW-1:0]        ctag  [NCELL+1];
  logic [RW-1:0]        crem  [NCELL+1];
  logic [RW-1:0]        croot [NCELL+1];
  logic [LW-1:0]        lvl_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v1 <= 1'b0;
      m_v2 <= 1'b0;
    end else begin
      m_v1 <= (st == E_MAG);
      m_v2 <= m_v1;
    end
    m_tag1 <= mag_cnt;
    m_tag2 <= m_tag1;
    sq_re  <= DW'(ar * ar);
    sq_im  <= DW'(ai * ai);
  end

  assign pw_sum   = sq_re + sq_im;
  assign cv[0]    = m_v2;
  assign ctag[0]  = m_tag2;
  assign crem[0]  = {pw_sum, 4'b0};
  assign croot[0] = '0;

  for (genvar gc = 0; gc < NCELL; gc++) begin : g_cell
    hfs_sqrt_cell #(
      .RW   (RW),
      .TW   (HW),
      .STEP (gc)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[gc]),
      .in_tag    (ctag[gc]),
      .in_rem    (crem[gc]),
      .in_root   (croot[gc]),
      .out_valid (cv[gc+1]),
      .out_tag   (ctag[gc+1]),
      .out_rem   (crem[gc+1]),
      .out_root  (croot[gc+1])
    );
  end

  assign lvl_full = LW'(croot[NCELL][NCELL-1:0]) << gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      spec_we <= 1'b0;
    end else begin
      spec_we <= cv[NCELL];
    end
    spec_addr <= ctag[NCELL];
    if (lvl_full > LW'(16'hFFFF)) begin
      spec_level <= 16'hFFFF;
    end else begin
      spec_level <= lvl_full[hfs_pkg::LEVEL_W-1:0];
    end
  end

  assign done = spec_we && (spec_addr == {HW{1'b1}}) && (st == E_DRAIN);

endmodule

>>> rtl/hann_fft_spectrum_analyzer.sv
// channel    | dir | payload                                                       | transfer
// audio      | in  | sample                                                        | valid & ready
// spectrum   | out | column, wave_level, spectrum_level, spectrum_valid, frame_end | valid & ready
// cfg        | in  | cfg_data (gain shift)                                         | cfg_we
//
// A sample passes the window, multiply and output states to reach the output register.
// The last sample of a frame then starts the transform: FRAME_SIZE/2*log2(FRAME_SIZE)
// butterflies, each through read, multiply, sum and two write states on the two-read,
// one-write transform memory, then the square-root cell chain; audio ready stays low.
// Reset is synchronous; stores need no clearing, levels read as zero until the first frame.
// A stalled output holds the next sample in its final step until the result slot frees.
module hann_fft_spectrum_analyzer #(
  parameter int FRAME_SIZE = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hfs_pkg::GAIN_W-1:0]        cfg_data,
  hfs_in_if.sink                            audio,
  hfs_out_if.source                         spectrum
);

  localparam int AW = $clog2(FRAME_SIZE);
  localparam int HW = AW - 1;
  localparam int SW = hfs_pkg::SAMPLE_W;
  localparam int CW = hfs_pkg::COMP_W;
  localparam int PW = 2 * SW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WIN  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;
  localparam logic [2:0] ST_FFT_UNUSED = 3'd4;

  logic [2:0] st;
  localparam logic [2:0] S_IDLE = {1'b0, ST_IDLE};
  localparam logic [2:0] S_WIN  = {1'b0, ST_WIN};
  localparam logic [2:0] S_MUL  = {1'b0, ST_MUL};
  localparam logic [2:0] S_OUT  = {1'b0, ST_OUT};
  localparam logic [2:0] S_FFT  = ST_FFT_UNUSED;

  logic [SW-1:0] win_rom [FRAME_SIZE];

  for (genvar gi = 0; gi < FRAME_SIZE; gi++) begin : g_win
    localparam logic [63:0] P = (64'(gi) << 32) / 64'(FRAME_SIZE - 1);
    assign win_rom[gi] = hfs_pkg::hfs_win(P);
  end

  logic [hfs_pkg::GAIN_W-1:0]  gain;
  logic [AW-1:0]               cnt;
  logic [AW-1:0]               col_reg;
  logic signed [SW-1:0]        s_reg;
  logic [SW-1:0]               win_q;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        prod_rnd;
  logic [hfs_pkg::LEVEL_W-1:0] spec_mem [FRAME_SIZE/2];
  logic [hfs_pkg::LEVEL_W-1:0] spec_q;
  logic                        spec_ready;
  logic                        last;
  logic                        out_free;
  logic [AW-1:0]               rev_addr;

  logic                        out_valid;
  logic [hfs_pkg::COL_W-1:0]   out_column;
  logic [hfs_pkg::LEVEL_W-1:0] out_wave;
  logic [hfs_pkg::LEVEL_W-1:0] out_level;
  logic                        out_ready_flag;
  logic                        out_frame_end;

  logic                        load_we;
  logic                        eng_start;
  logic                        eng_done;
  logic                        spec_we;
  logic [HW-1:0]               spec_addr;
  logic [hfs_pkg::LEVEL_W-1:0] spec_level;

  assign last     = (col_reg == AW'(FRAME_SIZE - 1));
  assign out_free = !out_valid || spectrum.ready;
  assign load_we  = (st == S_OUT) && out_free;
  assign eng_start = load_we && last;
  assign prod_rnd = (prod + (prod[PW-1] ? PW'(32767) : PW'(32768))) >>> 16;

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_addr[b] = col_reg[AW-1-b];
    end
  end

  assign audio.ready             = (st == S_IDLE);
  assign spectrum.valid          = out_valid;
  assign spectrum.column         = out_column;
  assign spectrum.wave_level     = out_wave;
  assign spectrum.spectrum_level = out_level;
  assign spectrum.spectrum_valid = out_ready_flag;
  assign spectrum.frame_end      = out_frame_end;

  always_ff @(posedge clk) begin
    win_q  <= win_rom[col_reg];
    spec_q <= spec_mem[col_reg[AW-1:1]];
    if (spec_we) begin
      spec_mem[spec_addr] <= spec_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      cnt        <= '0;
      out_valid  <= 1'b0;
      spec_ready <= 1'b0;
      gain       <= hfs_pkg::GAIN_RESET;
    end else begin
      if (cfg_we) begin
        gain <= cfg_data;
      end
      if (spectrum.ready && !load_we) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (audio.valid) begin
            s_reg   <= audio.sample;
            col_reg <= cnt;
            st      <= S_WIN;
          end
        end
        S_WIN: st <= S_MUL;
        S_MUL: begin
          prod <= PW'(s_reg) * signed'(PW'({1'b0, win_q}));
          st   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_column     <= hfs_pkg::COL_W'(col_reg);
            out_wave       <= {~s_reg[SW-1], s_reg[SW-2:0]};
            out_level      <= spec_ready ? spec_q : '0;
            out_ready_flag <= spec_ready;
            out_frame_end  <= last;
            if (last) begin
              cnt <= '0;
              st  <= S_FFT;
            end else begin
              cnt <= cnt + 1'b1;
              st  <= S_IDLE;
            end
          end
        end
        S_FFT: begin
          if (eng_done) begin
            spec_ready <= 1'b1;
            st         <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  hfs_fft_engine #(
    .FRAME_SIZE (FRAME_SIZE)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .load_we    (load_we),
    .load_addr  (rev_addr),
    .load_re    (prod_rnd[CW-1:0]),
    .start      (eng_start),
    .gain       (gain),
    .done       (eng_done),
    .spec_we    (spec_we),
    .spec_addr  (spec_addr),
    .spec_level (spec_level)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    eng_done |=> (st == S_IDLE) && spec_ready)
    else $error("transform done did not return to idle");

  a_start_fft: assert property (@(posedge clk) disable iff (rst)
    eng_start |=> (st == S_FFT) && out_valid && out_frame_end)
    else $error("frame end did not start transform");

  a_end_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_end |-> out_column == hfs_pkg::COL_W'(FRAME_SIZE - 1))
    else $error("frame end on wrong column");

endmodule
